@@ rtl/core/sliced_rate_pacer_defines.svh @@
// Assertion macros for the sliced rate pacer RTL, included by srp_engine.
// No dependencies; the clock is clk and the active-low reset is rst_n.
`ifndef SLICED_RATE_PACER_DEFINES_SVH
`define SLICED_RATE_PACER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/srp_pkg.sv @@
// Shared types and constants for the sliced rate pacer.
// No dependencies; every RTL module of the block refers to it by scoped names.
`default_nettype none

package srp_pkg;

    localparam int TIME_WIDTH_DEF  = 48;
    localparam int COUNT_WIDTH_DEF = 24;

    localparam int TALLY_W     = 20;
    localparam int INDEX_W     = 10;
    localparam int WAIT_W      = 20;
    localparam int OUT_COUNT_W = 24;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_IDX_W   = 2;

    localparam logic [WAIT_W-1:0]  ONE_SECOND_US = 20'd1000000;
    localparam logic [TALLY_W-1:0] TALLY_MAX     = '1;
    localparam logic [INDEX_W-1:0] INDEX_MAX     = '1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_QUOTA       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_US          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICES_PER_SECOND = 2'd2;

    localparam logic [TALLY_W-1:0] SLICE_QUOTA_RST       = 20'd10;
    localparam logic [19:0]        SLICE_US_RST          = 20'd100000;
    localparam logic [INDEX_W-1:0] SLICES_PER_SECOND_RST = 10'd10;

    typedef logic [OUT_COUNT_W-1:0] count_out_t;

    typedef struct packed {
        logic [TALLY_W-1:0] slice_quota;
        logic [19:0]        slice_us;
        logic [INDEX_W-1:0] slices_per_second;
    } cfg_t;

    typedef struct packed {
        logic [WAIT_W-1:0] wait_us;
        logic              second_closed;
        count_out_t        closed_second_count;
        count_out_t        max_per_second;
        count_out_t        min_per_second;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/srp_cfg.sv @@
// Configuration registers of the sliced rate pacer.
// Depends on srp_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module srp_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [srp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [srp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output srp_pkg::cfg_t                         cfg
);

    srp_pkg::cfg_t cfg_reg;
    srp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                srp_pkg::CFG_SLICE_QUOTA:       cfg_next.slice_quota = cfg_data;
                srp_pkg::CFG_SLICE_US:          cfg_next.slice_us = cfg_data;
                srp_pkg::CFG_SLICES_PER_SECOND:
                    cfg_next.slices_per_second = cfg_data[srp_pkg::INDEX_W-1:0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slice_quota       <= srp_pkg::SLICE_QUOTA_RST;
            cfg_reg.slice_us          <= srp_pkg::SLICE_US_RST;
            cfg_reg.slices_per_second <= srp_pkg::SLICES_PER_SECOND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/core/srp_in_reg.sv @@
// Input register stage of the sliced rate pacer.
// Depends on srp_pkg only for the default of its TIME_WIDTH parameter.
`default_nettype none

module srp_in_reg #(
    parameter int TIME_WIDTH = srp_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  kind,
    input  wire logic [TIME_WIDTH-1:0] now_us,
    input  wire logic                  advance,
    output logic                       item_valid,
    output logic                       item_kind,
    output logic [TIME_WIDTH-1:0]      item_now
);

    logic                  valid_reg;
    logic                  valid_next;
    logic                  kind_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic                  load;

    // hold the item while the result stage is blocked
    assign in_stall = valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= kind;
            now_reg  <= now_us;
        end
    end

    assign item_valid = valid_reg;
    assign item_kind  = kind_reg;
    assign item_now   = now_reg;

endmodule

`default_nettype wire

@@ rtl/core/srp_engine.sv @@
// Pacing state and single-pass update logic of the sliced rate pacer.
// Depends on srp_pkg and on sliced_rate_pacer_defines.svh for assertions.
`default_nettype none

`include "sliced_rate_pacer_defines.svh"

module srp_engine #(
    parameter int TIME_WIDTH  = srp_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = srp_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  srp_pkg::cfg_t              cfg,
    input  wire logic                  fire,
    input  wire logic                  item_kind,
    input  wire logic [TIME_WIDTH-1:0] item_now,
    output srp_pkg::result_t           res
);

    localparam int TallyW = srp_pkg::TALLY_W;
    localparam int IndexW = srp_pkg::INDEX_W;
    localparam int ProdW  = 20 + IndexW;
    localparam int TgtW   = ProdW + 1;
    localparam int SumW   = ((COUNT_WIDTH > TallyW) ? COUNT_WIDTH : TallyW) + 1;

    typedef logic [TIME_WIDTH-1:0]  time_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [SumW-1:0]        sum_t;
    typedef logic [TgtW-1:0]        tgt_t;

    time_t              mark_reg,   mark_next;
    logic [TallyW-1:0]  tally_reg,  tally_next;
    logic [TallyW-1:0]  aq_reg,     aq_next;
    logic [IndexW-1:0]  idx_reg,    idx_next;
    count_t             st_reg,     st_next;
    count_t             max_reg,    max_next;
    count_t             min_reg,    min_next;

    logic [TallyW-1:0]  tally_inc;
    logic [IndexW-1:0]  idx_inc;
    logic               slice_end;
    time_t              used;
    logic [ProdW-1:0]   prod;
    tgt_t               target;
    tgt_t               due;
    time_t              target_t;
    sum_t               st_sum;
    count_t             st_sat;
    logic               closed;
    logic               quota_hold;
    logic [srp_pkg::WAIT_W-1:0] wait_close;
    tgt_t               wait_slice;

    assign tally_inc = (tally_reg < srp_pkg::TALLY_MAX) ? tally_reg + 1'b1 : tally_reg;
    assign idx_inc   = (idx_reg < srp_pkg::INDEX_MAX) ? idx_reg + 1'b1 : idx_reg;
    assign slice_end = (tally_inc >= cfg.slice_quota) || (tally_inc >= aq_reg);

    // elapsed time, clamped at zero for a clock behind the mark
    assign used = (item_now > mark_reg) ? item_now - mark_reg : '0;

    assign prod     = cfg.slice_us * idx_reg;
    assign target   = {1'b0, prod} + tgt_t'(cfg.slice_us);
    assign target_t = time_t'(target);
    // schedule point of the slice just ended: index after its saturating advance
    assign due      = (idx_reg < srp_pkg::INDEX_MAX) ? target : tgt_t'(prod);

    assign st_sum = sum_t'(st_reg) + sum_t'(tally_inc);
    assign st_sat = (st_sum > sum_t'({COUNT_WIDTH{1'b1}})) ? '1 : count_t'(st_sum);

    assign wait_close = srp_pkg::ONE_SECOND_US - used[srp_pkg::WAIT_W-1:0];
    assign wait_slice = due - used[TgtW-1:0];

    always_comb
    begin
        mark_next  = mark_reg;
        tally_next = tally_reg;
        aq_next    = aq_reg;
        idx_next   = idx_reg;
        st_next    = st_reg;
        max_next   = max_reg;
        min_next   = min_reg;
        closed     = 1'b0;
        quota_hold = 1'b0;
        res.wait_us             = '0;
        res.second_closed       = 1'b0;
        res.closed_second_count = '0;

        if (!item_kind)
        begin
            mark_next = item_now;
        end
        else
        begin
            tally_next = tally_inc;
            if (slice_end)
            begin
                // adapt the quota to the pace seen against the schedule
                if ((used > target_t) && (aq_reg > 1))
                begin
                    aq_next = aq_reg - 1'b1;
                end
                else if ((aq_reg < cfg.slice_quota) && (used < target_t))
                begin
                    aq_next    = aq_reg + 1'b1;
                    quota_hold = 1'b1;
                end

                if (!quota_hold)
                begin
                    idx_next   = idx_inc;
                    st_next    = st_sat;
                    tally_next = '0;
                    if ((idx_inc >= cfg.slices_per_second)
                        || (used > time_t'(srp_pkg::ONE_SECOND_US)))
                    begin
                        closed = 1'b1;
                        if (used <= time_t'(srp_pkg::ONE_SECOND_US))
                        begin
                            if (wait_close != srp_pkg::ONE_SECOND_US)
                                res.wait_us = wait_close;
                            mark_next = mark_reg + time_t'(srp_pkg::ONE_SECOND_US);
                        end
                        else
                        begin
                            mark_next = item_now;
                        end
                    end
                    else if (used < time_t'(due))
                    begin
                        if (wait_slice < tgt_t'(srp_pkg::ONE_SECOND_US))
                            res.wait_us = wait_slice[srp_pkg::WAIT_W-1:0];
                    end

                    if (closed)
                    begin
                        if (st_sat > max_reg)
                            max_next = st_sat;
                        if ((st_sat < min_reg) || (min_reg == '0))
                            min_next = st_sat;
                        res.second_closed       = 1'b1;
                        res.closed_second_count = srp_pkg::count_out_t'(st_sat);
                        st_next  = '0;
                        idx_next = '0;
                    end
                end
            end
        end

        res.max_per_second = srp_pkg::count_out_t'(max_next);
        res.min_per_second = srp_pkg::count_out_t'(min_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg  <= '0;
            tally_reg <= '0;
            aq_reg    <= TallyW'(1);
            idx_reg   <= '0;
            st_reg    <= '0;
            max_reg   <= '0;
            min_reg   <= '0;
        end
        else if (fire)
        begin
            mark_reg  <= mark_next;
            tally_reg <= tally_next;
            aq_reg    <= aq_next;
            idx_reg   <= idx_next;
            st_reg    <= st_next;
            max_reg   <= max_next;
            min_reg   <= min_next;
        end
    end

    `SRP_ASSERT_IMP(a_wait_below_second, fire, res.wait_us < srp_pkg::ONE_SECOND_US, "srp: wait of a second or more")
    `SRP_ASSERT_IMP(a_count_only_on_close, fire && !res.second_closed, res.closed_second_count == '0, "srp: count without a close")
    `SRP_ASSERT_NXT(a_close_clears, fire && res.second_closed, (idx_reg == '0) && (st_reg == '0), "srp: close left slice state")
    `SRP_ASSERT_IMP(a_quota_nonzero, 1'b1, aq_reg != '0, "srp: adaptive quota reached zero")
    `SRP_ASSERT_IMP(a_min_not_above_max, 1'b1, min_reg <= max_reg, "srp: minimum rate above maximum")

endmodule

`default_nettype wire

@@ rtl/core/srp_out_reg.sv @@
// Result register stage of the sliced rate pacer.
// Depends on srp_pkg for result_t.
`default_nettype none

module srp_out_reg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         fire,
    input  srp_pkg::result_t  res,
    input  wire logic         out_stall,
    output logic              out_valid,
    output logic              advance,
    output srp_pkg::result_t  out_res
);

    logic             valid_reg;
    logic             valid_next;
    srp_pkg::result_t res_reg;

    // free when empty or when the held item leaves this cycle
    assign advance    = !valid_reg || !out_stall;
    assign valid_next = fire || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

@@ rtl/core/sliced_rate_pacer.sv @@
// Sliced rate pacer: one item per cycle while out_stall is low; one result per item.
// An accepted item is held in the input register; its result is presented from the
// output register in the cycle after the item leaves the input register.
// The rate is set by the combinational state update in srp_engine (one 20x10 multiply).
// Reset (rst_n, asynchronous, active low) restores the register defaults,
// clears the pacing state with the adaptive quota at one, and empties both stages.
`default_nettype none

module sliced_rate_pacer #(
    parameter int TIME_WIDTH  = srp_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = srp_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input item channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            kind,
    input  wire logic [TIME_WIDTH-1:0]           now_us,
    // result item channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [srp_pkg::WAIT_W-1:0]           wait_us,
    output logic                                 second_closed,
    output logic [srp_pkg::OUT_COUNT_W-1:0]      closed_second_count,
    output logic [srp_pkg::OUT_COUNT_W-1:0]      max_per_second,
    output logic [srp_pkg::OUT_COUNT_W-1:0]      min_per_second,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [srp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [srp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    srp_pkg::cfg_t    cfg;
    srp_pkg::result_t res;
    srp_pkg::result_t out_res;

    logic                  item_valid;
    logic                  item_kind;
    logic [TIME_WIDTH-1:0] item_now;
    logic                  advance;
    logic                  fire;

    // Own registers; user must land writes only while idle; block does not enforce it.
    srp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Capture each accepted item; hold it while the result stage is full and stalled.
    srp_in_reg #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .now_us     (now_us),
        .advance    (advance),
        .item_valid (item_valid),
        .item_kind  (item_kind),
        .item_now   (item_now)
    );

    // An item is processed, and the pacing state advanced, in the same cycle
    // that its result is written into the output register.
    assign fire = item_valid && advance;

    srp_engine #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fire      (fire),
        .item_kind (item_kind),
        .item_now  (item_now),
        .res       (res)
    );

    // The output register parts the two sides: a waiting result does not stop
    // the next item being captured at the input.
    srp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .advance   (advance),
        .out_res   (out_res)
    );

    assign wait_us             = out_res.wait_us;
    assign second_closed       = out_res.second_closed;
    assign closed_second_count = out_res.closed_second_count;
    assign max_per_second      = out_res.max_per_second;
    assign min_per_second      = out_res.min_per_second;

endmodule

`default_nettype wire

@@ dv/sliced_rate_pacer_tb.sv @@
// Self-checking testbench for sliced_rate_pacer: directed pacing cases, then random phases.
// Depends on srp_pkg and the sliced_rate_pacer RTL only; reads no files.
`timescale 1ns / 1ps

module sliced_rate_pacer_tb;

    import srp_pkg::*;

    localparam int TW = TIME_WIDTH_DEF;

    // item kinds on the input channel
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_PACED = 1'b1;

    localparam logic [TW-1:0]       TIME_TOP        = '1;
    localparam longint unsigned     ONE_SEC_US      = 64'd1000000;
    localparam logic [OUT_COUNT_W-1:0] COUNT_TOP    = '1;

    localparam int RANDOM_PHASES   = 14;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int DRAIN_CYCLES    = 6;
    localparam int WATCHDOG_CYCLES = 4000;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   kind;
    logic [TW-1:0]          now_us;
    logic                   out_valid;
    logic                   out_stall;
    logic [WAIT_W-1:0]      wait_us;
    logic                   second_closed;
    logic [OUT_COUNT_W-1:0] closed_second_count;
    logic [OUT_COUNT_W-1:0] max_per_second;
    logic [OUT_COUNT_W-1:0] min_per_second;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    sliced_rate_pacer u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .kind                (kind),
        .now_us              (now_us),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .wait_us             (wait_us),
        .second_closed       (second_closed),
        .closed_second_count (closed_second_count),
        .max_per_second      (max_per_second),
        .min_per_second      (min_per_second),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Pacing predictor: register copy and pacing state, updated per item
    // in acceptance order.
    // ------------------------------------------------------------------
    logic [TALLY_W-1:0]     set_quota;
    logic [19:0]            set_slice_us;
    logic [INDEX_W-1:0]     set_slices;

    logic [TW-1:0]          mark_us;
    logic [TALLY_W-1:0]     tally_in_slice;
    logic [TALLY_W-1:0]     quota_now;
    logic [INDEX_W-1:0]     slice_no;
    logic [OUT_COUNT_W-1:0] tally_in_second;
    logic [OUT_COUNT_W-1:0] peak_rate;
    logic [OUT_COUNT_W-1:0] floor_rate;

    result_t pacing_results_due[$];
    result_t oldest_due;
    int      mismatch_count;
    int      send_gap_odds;
    int      stall_odds;
    int      quiet_cycles;

    function automatic result_t pace_transaction(input logic item_kind,
                                                 input logic [TW-1:0] t_us);
        result_t     r;
        logic [63:0] used;
        logic [63:0] target;
        logic [63:0] sched;
        logic [63:0] sum;
        logic [63:0] wait_v;
        logic [63:0] count;
        logic        closed;
        logic        raised;
        wait_v = '0;
        count  = '0;
        closed = 1'b0;
        if (item_kind == KIND_START)
        begin
            mark_us = t_us;
        end
        else
        begin
            if (tally_in_slice != TALLY_MAX)
                tally_in_slice = tally_in_slice + 1'b1;
            if (tally_in_slice >= set_quota || tally_in_slice >= quota_now)
            begin
                // elapsed time clamps at zero when now lies before the mark
                used   = (t_us > mark_us) ? 64'(t_us - mark_us) : 64'd0;
                target = 64'(set_slice_us) * (64'(slice_no) + 64'd1);
                raised = 1'b0;
                if (used > target && quota_now > 1)
                    quota_now = quota_now - 1'b1;
                else if (quota_now < set_quota && used < target)
                begin
                    quota_now = quota_now + 1'b1;
                    raised    = 1'b1;
                end
                if (!raised)
                begin
                    if (slice_no != INDEX_MAX)
                        slice_no = slice_no + 1'b1;
                    sum = 64'(tally_in_second) + 64'(tally_in_slice);
                    tally_in_second = (sum > 64'(COUNT_TOP)) ? COUNT_TOP
                                                             : sum[OUT_COUNT_W-1:0];
                    tally_in_slice  = '0;
                    sched = 64'(set_slice_us) * 64'(slice_no);
                    if (slice_no >= set_slices || used > ONE_SEC_US)
                    begin
                        closed = 1'b1;
                        if (used <= ONE_SEC_US)
                        begin
                            wait_v  = ONE_SEC_US - used;
                            mark_us = mark_us + TW'(ONE_SEC_US);
                        end
                        else
                        begin
                            mark_us = t_us;
                        end
                    end
                    else if (used < sched)
                    begin
                        wait_v = sched - used;
                    end
                    if (wait_v >= ONE_SEC_US)
                        wait_v = '0;
                    if (closed)
                    begin
                        if (tally_in_second > peak_rate)
                            peak_rate = tally_in_second;
                        if (tally_in_second < floor_rate || floor_rate == 0)
                            floor_rate = tally_in_second;
                        count           = 64'(tally_in_second);
                        tally_in_second = '0;
                        slice_no        = '0;
                    end
                end
            end
        end
        r.wait_us             = wait_v[WAIT_W-1:0];
        r.second_closed       = closed;
        r.closed_second_count = count[OUT_COUNT_W-1:0];
        r.max_per_second      = peak_rate;
        r.min_per_second      = floor_rate;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Send one item, optionally after an idle burst; hold the payload until
    // the block takes it, then record what the result must be.
    task automatic send_item(input logic item_kind, input logic [TW-1:0] t_us);
        if (send_gap_odds != 0 && $urandom_range(1, 100) <= send_gap_odds)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= item_kind;
        now_us   <= t_us;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pacing_results_due.push_back(pace_transaction(item_kind, t_us));
    endtask

    // Drop valid, wait for every outstanding result, then let the pipe drain.
    task automatic await_idle();
        in_valid <= 1'b0;
        while (pacing_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all three registers back to back while the block is idle.
    task automatic write_config(input logic [TALLY_W-1:0] quota,
                                input logic [19:0] slice_len,
                                input logic [INDEX_W-1:0] slices);
        await_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SLICE_QUOTA;
        cfg_data  <= CFG_DATA_W'(quota);
        @(posedge clk);
        cfg_index <= CFG_SLICE_US;
        cfg_data  <= CFG_DATA_W'(slice_len);
        @(posedge clk);
        cfg_index <= CFG_SLICES_PER_SECOND;
        cfg_data  <= CFG_DATA_W'(slices);
        @(posedge clk);
        cfg_we       <= 1'b0;
        set_quota    = quota;
        set_slice_us = slice_len;
        set_slices   = slices;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts, and an in-order field check.
    // ------------------------------------------------------------------
    initial
    begin : result_stall
        int burst;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_odds != 0 && $urandom_range(1, 100) <= stall_odds)
            begin
                burst = $urandom_range(1, 17);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic check_field(input string field, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pacing_results_due.size() == 0)
            begin
                $display("%0t: result with no item outstanding, expected none, actual wait_us %0d",
                         $time, wait_us);
                mismatch_count++;
            end
            else
            begin
                oldest_due = pacing_results_due.pop_front();
                check_field("wait_us", oldest_due.wait_us, wait_us);
                check_field("second_closed", oldest_due.second_closed, second_closed);
                check_field("closed_second_count", oldest_due.closed_second_count,
                            closed_second_count);
                check_field("max_per_second", oldest_due.max_per_second, max_per_second);
                check_field("min_per_second", oldest_due.min_per_second, min_per_second);
            end
        end
    end

    // Abort when neither channel has moved an item for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_CYCLES);
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers: quota raising, an on-schedule slice, a slice not yet due,
    // time before the mark and a window longer than a second.
    task automatic test_default_pacing();
        send_item(KIND_START, '0);
        send_item(KIND_PACED, '0);
        send_item(KIND_PACED, TW'(50));
        send_item(KIND_PACED, TW'(100000));
        send_item(KIND_PACED, TW'(120000));
        send_item(KIND_START, TIME_TOP);
        send_item(KIND_PACED, '0);
        send_item(KIND_PACED, '0);
        send_item(KIND_START, '0);
        send_item(KIND_PACED, TW'(5000000));
    endtask

    // Widest slice: a slice that ends before its schedule raises the adaptive quota and gives no wait.
    task automatic test_wait_limits();
        write_config('1, '1, '1);
        send_item(KIND_START, TW'(100));
        send_item(KIND_PACED, TW'(100));
        send_item(KIND_PACED, TW'(700100));
        send_item(KIND_PACED, TW'(1100101));
    endtask

    // Mark at the top of the time range: advance wraps, then a real wait.
    task automatic test_mark_wrap();
        write_config(TALLY_W'(1), 20'd1000, INDEX_W'(1));
        send_item(KIND_START, TIME_TOP);
        send_item(KIND_PACED, TIME_TOP);
        send_item(KIND_PACED, TW'(1000));
        send_item(KIND_PACED, TW'(2499999));
    endtask

    // Zero quota and zero slices: every paced item ends a slice and a second.
    task automatic test_zero_registers();
        write_config('0, '0, '0);
        send_item(KIND_START, '0);
        send_item(KIND_PACED, TW'(10));
        send_item(KIND_PACED, TW'(10));
        send_item(KIND_PACED, TW'(2000000));
        send_item(KIND_PACED, TW'(1));
    endtask

    // Random phases: mostly monotonic time at about the paced rate, with long
    // jumps, restarts, steps backwards and fully random items mixed in.
    task automatic test_random_pacing();
        logic [TALLY_W-1:0] quota;
        logic [19:0]        slice_len;
        logic [INDEX_W-1:0] slices;
        logic [TW-1:0]      clock_now;
        longint unsigned    divisor;
        longint unsigned    base_step;
        int                 pick;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                3:
                begin
                    quota     = TALLY_W'(1);
                    slice_len = 20'd1000;
                    slices    = INDEX_W'(1);
                end
                6:
                begin
                    quota     = TALLY_W'(1000000);
                    slice_len = 20'd1000000;
                    slices    = INDEX_W'(1000);
                end
                9:
                begin
                    quota     = '1;
                    slice_len = '1;
                    slices    = '1;
                end
                11:
                begin
                    quota     = '0;
                    slice_len = '0;
                    slices    = '0;
                end
                12:
                begin
                    quota     = SLICE_QUOTA_RST;
                    slice_len = SLICE_US_RST;
                    slices    = SLICES_PER_SECOND_RST;
                end
                default:
                begin
                    quota     = TALLY_W'($urandom_range(1, 16));
                    slice_len = 20'($urandom_range(1000, 50000));
                    slices    = INDEX_W'($urandom_range(1, 12));
                end
            endcase
            write_config(quota, slice_len, slices);

            // no idling at all in the closing phase
            if (phase == RANDOM_PHASES - 1)
            begin
                send_gap_odds = 0;
                stall_odds    = 0;
            end
            else
            begin
                send_gap_odds = 15 * $urandom_range(0, 3);
                stall_odds    = 15 * $urandom_range(0, 3);
            end

            divisor   = (quota == 0) ? 1 : ((quota > 32) ? 32 : longint'(quota));
            base_step = longint'(slice_len) / divisor + 1;
            clock_now = TW'({$urandom, $urandom});
            send_item(KIND_START, clock_now);
            repeat (ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    clock_now = clock_now + TW'($urandom_range(0, 32'(2 * base_step)));
                    send_item(KIND_PACED, clock_now);
                end
                else if (pick < 85)
                begin
                    clock_now = clock_now + TW'($urandom_range(1000001, 3000000));
                    send_item(KIND_PACED, clock_now);
                end
                else if (pick < 89)
                begin
                    send_item(KIND_START, clock_now);
                end
                else if (pick < 93)
                begin
                    clock_now = clock_now - TW'($urandom_range(0, 200000));
                    send_item(KIND_PACED, clock_now);
                end
                else
                begin
                    send_item(1'($urandom), TW'({$urandom, $urandom}));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence: hold reset, run the tests in turn, drain and report.
    // ------------------------------------------------------------------
    initial
    begin
        in_valid  <= 1'b0;
        kind      <= KIND_START;
        now_us    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_SLICE_QUOTA;
        cfg_data  <= '0;
        rst_n     <= 1'b0;

        mismatch_count  = 0;
        quiet_cycles    = 0;
        send_gap_odds   = 20;
        stall_odds      = 20;
        set_quota       = SLICE_QUOTA_RST;
        set_slice_us    = SLICE_US_RST;
        set_slices      = SLICES_PER_SECOND_RST;
        mark_us         = '0;
        tally_in_slice  = '0;
        quota_now       = TALLY_W'(1);
        slice_no        = '0;
        tally_in_second = '0;
        peak_rate       = '0;
        floor_rate      = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_default_pacing();
        test_wait_limits();
        test_mark_wrap();
        test_zero_registers();
        test_random_pacing();

        await_idle();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
